@@ design/eets_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package eets_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int TIME_BITS_DEF = 32;

   typedef enum logic [2:0] {
      CMD_ATTACH   = 3'd0,
      CMD_DETACH   = 3'd1,
      CMD_PRIORITY = 3'd2,
      CMD_YIELD    = 3'd3,
      CMD_MARK     = 3'd4,
      CMD_SCHEDULE = 3'd5
   } cmd_type;

   localparam logic [3:0] ST_STARTING = 4'd1;
   localparam logic [3:0] ST_WAIT     = 4'd2;
   localparam logic [3:0] ST_TIMEOUT  = 4'd8;
   localparam logic [3:0] ST_NOW      = 4'd13;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_SCAN,
      S_FINISH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [31:0] now;
      logic [31:0] wait_ticks;
      logic [3:0]  status_code;
      logic [7:0]  priority_req;
      logic [31:0] nice;
      logic        flag_value;
   } req_payload_type;

   typedef struct packed {
      logic               any_thread;
      logic [3:0]         selected_slot;
      logic [31:0]        sleep_ticks;
      logic signed [31:0] late_ticks;
      logic [3:0]         selected_status;
      logic [4:0]         thread_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ design/eets_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface eets_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [3:0]  slot;
   logic [31:0] now;
   logic [31:0] wait_ticks;
   logic [3:0]  status_code;
   logic [7:0]  priority_req;
   logic [31:0] nice;
   logic        flag_value;

   modport source (
      output valid, cmd, slot, now, wait_ticks, status_code, priority_req, nice, flag_value,
      input  ready
   );
   modport sink (
      input  valid, cmd, slot, now, wait_ticks, status_code, priority_req, nice, flag_value,
      output ready
   );
endinterface

interface eets_rsp_if;
   logic               valid;
   logic               ready;
   logic               any_thread;
   logic [3:0]         selected_slot;
   logic [31:0]        sleep_ticks;
   logic signed [31:0] late_ticks;
   logic [3:0]         selected_status;
   logic [4:0]         thread_count;

   modport source (
      output valid, any_thread, selected_slot, sleep_ticks, late_ticks, selected_status,
             thread_count,
      input  ready
   );
   modport sink (
      input  valid, any_thread, selected_slot, sleep_ticks, late_ticks, selected_status,
             thread_count,
      output ready
   );
endinterface

`default_nettype wire

@@ design/eets_pick.sv @@
`timescale 1ns / 1ps
`default_nettype none

module eets_pick
   import eets_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 cand_ok,
   input  logic                 have_best,
   input  logic [TIME_BITS-1:0] cand_evt,
   input  logic [7:0]           cand_prio,
   input  logic [TIME_BITS-1:0] best_evt,
   input  logic [7:0]           best_prio,
   output logic                 replace
);

   logic earlier;
   logic tie_wins;

   assign earlier  = best_evt > cand_evt;
   assign tie_wins = (best_evt == cand_evt) && (cand_prio > best_prio);
   // with no running choice yet the first usable slot is taken outright
   assign replace  = cand_ok && (!have_best || earlier || tie_wins);

endmodule

`default_nettype wire

@@ design/eets_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module eets_engine
   import eets_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  req_payload_type req,
   output logic            ready,
   output logic            done,
   input  logic            out_free,
   output rsp_payload_type rsp
);

   localparam int SB = $clog2(SLOTS);
   localparam int CB = $clog2(SLOTS + 1);
   localparam int DB = (TIME_BITS > 32) ? TIME_BITS : 32;

   typedef struct packed {
      logic [TIME_BITS-1:0] evt;
      logic [7:0]           prio;
      logic [TIME_BITS-1:0] nice;
      logic [3:0]           status;
   } entry_type;

   entry_type mem [SLOTS];
   entry_type rd_data_ff;
   logic          rd_en;
   logic [SB-1:0] rd_addr;
   logic          wr_en;
   logic [SB-1:0] wr_addr;
   entry_type     wr_data;

   state_type state_ff, state_in;
   req_payload_type req_ff;

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] mark_ff, mark_in;
   logic [SB-1:0]    cur_ff, cur_in;
   logic [CB-1:0]    count_ff, count_in;
   logic [3:0]       cur_status_ff, cur_status_in;

   logic [SB-1:0] addr_ff;
   logic [CB-1:0] rem_ff;
   logic [SB-1:0] pend_idx_ff;
   logic          first_ff;
   logic [SB-1:0] best_idx_ff;
   entry_type     best_ff;
   logic          have_ff;
   logic [31:0]        sleep_ff;
   logic signed [31:0] late_ff;

   logic [SB-1:0]        slot_idx;
   logic [SB-1:0]        req_slot_idx;
   logic                 in_range;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] yield_evt;
   logic [SB-1:0]        cur_next;
   logic [SB-1:0]        addr_next;
   logic                 cand_ok;
   logic                 replace;
   logic                 due_later;
   logic [DB-1:0]        diff;
   logic [3:0]           new_status;

   assign slot_idx     = SB'(req_ff.slot);
   assign req_slot_idx = SB'(req.slot);
   assign in_range     = 32'(req_ff.slot) < SLOTS;
   assign now_t        = TIME_BITS'(req_ff.now);
   assign cur_next     = (cur_ff == SB'(SLOTS - 1)) ? '0 : cur_ff + SB'(1);
   assign addr_next    = (addr_ff == SB'(SLOTS - 1)) ? '0 : addr_ff + SB'(1);

   // zero wait falls back on the slot's nice value
   assign yield_evt = (req_ff.status_code == ST_NOW) ? now_t :
      now_t + ((req_ff.wait_ticks != '0) ? TIME_BITS'(req_ff.wait_ticks) : rd_data_ff.nice);

   assign cand_ok = valid_ff[pend_idx_ff] && !mark_ff[pend_idx_ff];

   eets_pick #(
      .TIME_BITS(TIME_BITS)
   ) u_pick (
      .cand_ok  (cand_ok),
      .have_best(have_ff),
      .cand_evt (rd_data_ff.evt),
      .cand_prio(rd_data_ff.prio),
      .best_evt (best_ff.evt),
      .best_prio(best_ff.prio),
      .replace  (replace)
   );

   assign due_later  = best_ff.evt > now_t;
   assign diff       = DB'(best_ff.evt) - DB'(now_t);
   assign new_status = (due_later && (best_ff.status >= ST_WAIT)) ? ST_TIMEOUT : best_ff.status;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req.cmd == CMD_SCHEDULE) begin
                  state_in = (count_ff == '0) ? S_DONE : S_SCAN;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_APPLY:  state_in = S_DONE;
         S_SCAN:   state_in = (rem_ff == '0) ? S_FINISH : S_SCAN;
         S_FINISH: state_in = S_DONE;
         S_DONE:   state_in = out_free ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // memory ports and handshake
   always_comb begin
      ready   = 1'b0;
      done    = 1'b0;
      rd_en   = 1'b0;
      rd_addr = addr_ff;
      wr_en   = 1'b0;
      wr_addr = slot_idx;
      wr_data = rd_data_ff;
      case (state_ff)
         S_IDLE: begin
            ready   = 1'b1;
            rd_en   = start;
            rd_addr = ((req.cmd == CMD_YIELD) || (req.cmd == CMD_SCHEDULE)) ?
                      cur_ff : req_slot_idx;
         end
         S_APPLY: begin
            case (req_ff.cmd)
               CMD_ATTACH: begin
                  wr_en   = in_range;
                  wr_data = '{evt: '0, prio: req_ff.priority_req,
                              nice: TIME_BITS'(req_ff.nice), status: ST_STARTING};
               end
               CMD_PRIORITY: begin
                  wr_en        = in_range;
                  wr_data.prio = req_ff.priority_req;
               end
               CMD_YIELD: begin
                  wr_en          = 1'b1;
                  wr_addr        = cur_ff;
                  wr_data.evt    = yield_evt;
                  wr_data.status = req_ff.status_code;
               end
               default: wr_en = 1'b0;
            endcase
         end
         S_SCAN: begin
            rd_en   = rem_ff != '0;
            rd_addr = addr_ff;
         end
         S_FINISH: begin
            wr_en          = 1'b1;
            wr_addr        = best_idx_ff;
            wr_data        = best_ff;
            wr_data.status = new_status;
         end
         S_DONE:  done = 1'b1;
         default: ready = 1'b0;
      endcase
   end

   // slot flags, count and current slot
   always_comb begin
      valid_in      = valid_ff;
      mark_in       = mark_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      cur_status_in = cur_status_ff;
      case (state_ff)
         S_APPLY: begin
            case (req_ff.cmd)
               CMD_ATTACH: begin
                  if (in_range) begin
                     if (!valid_ff[slot_idx]) count_in = count_ff + CB'(1);
                     valid_in[slot_idx] = 1'b1;
                     mark_in[slot_idx]  = 1'b0;
                     if (slot_idx == cur_ff) cur_status_in = ST_STARTING;
                  end
               end
               CMD_DETACH: begin
                  if (in_range && valid_ff[slot_idx]) begin
                     valid_in[slot_idx] = 1'b0;
                     count_in           = count_ff - CB'(1);
                  end
               end
               CMD_YIELD: cur_status_in = req_ff.status_code;
               CMD_MARK: begin
                  if (in_range) mark_in[slot_idx] = req_ff.flag_value;
               end
               default: count_in = count_ff;
            endcase
         end
         S_FINISH: begin
            cur_in               = best_idx_ff;
            cur_status_in        = new_status;
            mark_in[best_idx_ff] = 1'b0;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         mark_ff       <= '0;
         cur_ff        <= '0;
         count_ff      <= '0;
         cur_status_ff <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         mark_ff       <= mark_in;
         cur_ff        <= cur_in;
         count_ff      <= count_in;
         cur_status_ff <= cur_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // scan bookkeeping: the current slot is read first to seed the choice,
   // then every slot after it, wrapping round to itself
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_ff   <= req;
               sleep_ff <= '0;
               late_ff  <= '0;
               first_ff <= 1'b1;
               addr_ff  <= cur_next;
               rem_ff   <= CB'(SLOTS);
            end
         end
         S_SCAN: begin
            first_ff <= 1'b0;
            if (rem_ff != '0) begin
               pend_idx_ff <= addr_ff;
               addr_ff     <= addr_next;
               rem_ff      <= rem_ff - CB'(1);
            end
            if (first_ff) begin
               best_idx_ff <= cur_ff;
               best_ff     <= rd_data_ff;
               have_ff     <= valid_ff[cur_ff];
            end else if (replace) begin
               best_idx_ff <= pend_idx_ff;
               best_ff     <= rd_data_ff;
               have_ff     <= 1'b1;
            end
         end
         S_FINISH: begin
            if (due_later) begin
               sleep_ff <= 32'(diff[TIME_BITS-1:0]);
            end else begin
               late_ff <= diff[31:0];
            end
         end
         default: first_ff <= first_ff;
      endcase
   end

   assign rsp.any_thread      = count_ff != '0;
   assign rsp.selected_slot   = 4'(cur_ff);
   assign rsp.sleep_ticks     = sleep_ff;
   assign rsp.late_ticks      = late_ff;
   assign rsp.selected_status = cur_status_ff;
   assign rsp.thread_count    = 5'(count_ff);

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("attached count out of step with valid flags");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(SLOTS))
      else $error("attached count beyond slot total");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !wr_en)
      else $error("slot memory written during scan");

   a_mark_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> !mark_ff[cur_ff])
      else $error("chosen slot still marked after schedule");

endmodule

`default_nettype wire

@@ design/earliest_event_thread_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake       payload
// req_ch    in   valid / ready   cmd slot now wait_ticks status_code priority_req nice flag_value
// rsp_ch    out  valid / ready   any_thread selected_slot sleep_ticks late_ticks
//                                selected_status thread_count
//
// One request at a time. The slot memory has one read port and the scan reads one entry
// a cycle, the current slot first and then all slots after it. Other commands pass
// through a single apply step, and a schedule with nothing attached skips the scan.
// Synchronous active-high reset clears the valid and mark flags, the count and the
// current slot; slot memory contents are left as they are.
// The result register lets a new request in while the last result waits; the block
// holds its next result until that register is free.

module earliest_event_thread_scheduler
   import eets_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   eets_req_if.sink   req_ch,
   eets_rsp_if.source rsp_ch
);

   req_payload_type req;
   rsp_payload_type eng_rsp;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;
   logic            eng_ready;
   logic            eng_done;
   logic            out_free;
   logic            start;

   assign req.cmd          = req_ch.cmd;
   assign req.slot         = req_ch.slot;
   assign req.now          = req_ch.now;
   assign req.wait_ticks   = req_ch.wait_ticks;
   assign req.status_code  = req_ch.status_code;
   assign req.priority_req = req_ch.priority_req;
   assign req.nice         = req_ch.nice;
   assign req.flag_value   = req_ch.flag_value;

   assign req_ch.ready = eng_ready;
   assign start        = req_ch.valid && eng_ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   eets_engine #(
      .SLOTS    (SLOTS),
      .TIME_BITS(TIME_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req),
      .ready   (eng_ready),
      .done    (eng_done),
      .out_free(out_free),
      .rsp     (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done && out_free) rsp_ff <= eng_rsp;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.any_thread      = rsp_ff.any_thread;
   assign rsp_ch.selected_slot   = rsp_ff.selected_slot;
   assign rsp_ch.sleep_ticks     = rsp_ff.sleep_ticks;
   assign rsp_ch.late_ticks      = rsp_ff.late_ticks;
   assign rsp_ch.selected_status = rsp_ff.selected_status;
   assign rsp_ch.thread_count    = rsp_ff.thread_count;

endmodule

`default_nettype wire
